// ----- rtl/core/msp_pkg.sv -----
// Shared constants for the matrix saddle point finder.
// No dependencies; every module of the block imports this package.
package msp_pkg;

  localparam int ValueW         = 32;
  localparam int CfgDataW       = 7;
  localparam int CfgIdxW        = 2;
  localparam int PointIdxW      = 6;
  localparam int FifoDepth      = 4;
  localparam int DefMaxRows     = 64;
  localparam int DefMaxColumns  = 64;

  localparam logic [CfgIdxW-1:0] RegRowCount    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegColumnCount = CfgIdxW'(1);

endpackage

// ----- rtl/core/msp_front.sv -----
// Front end: configuration registers, matrix position tracking and item tagging.
// Depends on msp_pkg; feeds msp_fifo.
module msp_front import msp_pkg::*; #(
  parameter int MAX_ROWS    = DefMaxRows,
  parameter int MAX_COLUMNS = DefMaxColumns,
  localparam int RowW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int ColW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int RowCntW = $clog2(MAX_ROWS + 1),
  localparam int ColCntW = $clog2(MAX_COLUMNS + 1),
  localparam int ItemW   = ValueW + RowW + ColW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [ValueW-1:0]  element_value_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output logic                      item_valid_o,
  output logic [ItemW-1:0]          item_o,
  input  logic                      item_ready_i
);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic              row_end;
    logic              last;
  } item_t;

  logic [CfgDataW-1:0] row_cfg_q, col_cfg_q;
  logic [RowW-1:0]     row_q;
  logic [ColW-1:0]     col_q;
  logic [RowCntW-1:0]  row_cnt;
  logic [ColCntW-1:0]  col_cnt;
  logic                accept, row_end, last, cfg_hit;
  item_t               item;

  always_comb begin
    if (row_cfg_q == '0) begin
      row_cnt = RowCntW'(1);
    end else if (32'(row_cfg_q) > 32'(MAX_ROWS)) begin
      row_cnt = RowCntW'(MAX_ROWS);
    end else begin
      row_cnt = RowCntW'(row_cfg_q);
    end
    if (col_cfg_q == '0) begin
      col_cnt = ColCntW'(1);
    end else if (32'(col_cfg_q) > 32'(MAX_COLUMNS)) begin
      col_cnt = ColCntW'(MAX_COLUMNS);
    end else begin
      col_cnt = ColCntW'(col_cfg_q);
    end
  end

  assign row_end = (32'(col_q) + 32'd1) == 32'(col_cnt);
  assign last    = row_end && ((32'(row_q) + 32'd1) == 32'(row_cnt));
  assign accept  = push && item_ready_i;
  assign full    = !item_ready_i;
  assign cfg_hit = cfg_we_i && (cfg_index_i == RegRowCount || cfg_index_i == RegColumnCount);

  always_comb begin
    item.value   = element_value_i;
    item.row     = row_q;
    item.col     = col_q;
    item.row_end = row_end;
    item.last    = last;
  end

  assign item_valid_o = push;
  assign item_o       = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= CfgDataW'(1);
      col_cfg_q <= CfgDataW'(1);
      row_q     <= '0;
      col_q     <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == RegRowCount) begin
        row_cfg_q <= cfg_data_i;
      end else begin
        col_cfg_q <= cfg_data_i;
      end
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= last ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/msp_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on msp_pkg for its default depth.
module msp_fifo import msp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FifoDepth,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = 32'(count_q) < 32'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/msp_back.sv -----
// Back end: row minimum and column maximum tracking, final row walk, result register.
// Depends on msp_pkg; consumes items from msp_fifo.
module msp_back import msp_pkg::*; #(
  parameter int MAX_ROWS    = DefMaxRows,
  parameter int MAX_COLUMNS = DefMaxColumns,
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int ItemW = ValueW + RowW + ColW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  logic [ItemW-1:0]          item_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      found_o,
  output logic signed [ValueW-1:0]  point_value_o,
  output logic [PointIdxW-1:0]      point_row_o,
  output logic [PointIdxW-1:0]      point_column_o
);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic              row_end;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              uniq;
    logic [ValueW-1:0] max;
  } col_entry_t;

  typedef struct packed {
    logic              uniq;
    logic [ColW-1:0]   col;
    logic [ValueW-1:0] val;
  } row_entry_t;

  localparam logic [2:0] S_STREAM   = 3'd0;
  localparam logic [2:0] S_DRAIN    = 3'd1;
  localparam logic [2:0] S_WALK_ROW = 3'd2;
  localparam logic [2:0] S_WALK_COL = 3'd3;
  localparam logic [2:0] S_WALK_CHK = 3'd4;

  col_entry_t col_mem [MAX_COLUMNS];
  row_entry_t row_mem [MAX_ROWS];

  logic [2:0]        state_q, state_d;
  item_t             in_item, b_q;
  logic              b_valid_q;
  col_entry_t        col_rd_q, col_old, col_new, wr_entry_q;
  row_entry_t        row_rd_q, rmin_q, rmin_new;
  logic              wr_valid_q;
  logic [ColW-1:0]   wr_col_q;
  logic [ColW-1:0]   col_raddr;
  logic              take, col_re, hit, walk_done, load;
  logic [RowW-1:0]   walk_q, last_row_q;
  logic              out_valid_q, found_q;
  logic [ValueW-1:0] value_q;
  logic [RowW-1:0]   res_row_q;
  logic [ColW-1:0]   res_col_q;

  assign in_item      = item_i;
  assign item_ready_o = state_q == S_STREAM;
  assign take         = item_ready_o && item_valid_i;
  assign col_re       = take || state_q == S_WALK_COL;
  assign col_raddr    = take ? in_item.col : row_rd_q.col;

  always_comb begin
    col_old = (wr_valid_q && wr_col_q == b_q.col) ? wr_entry_q : col_rd_q;
    if (b_q.row == '0 || $signed(b_q.value) > $signed(col_old.max)) begin
      col_new.uniq = 1'b1;
      col_new.max  = b_q.value;
    end else if (b_q.value == col_old.max) begin
      col_new.uniq = 1'b0;
      col_new.max  = col_old.max;
    end else begin
      col_new = col_old;
    end
    if (b_q.col == '0 || $signed(b_q.value) < $signed(rmin_q.val)) begin
      rmin_new.uniq = 1'b1;
      rmin_new.col  = b_q.col;
      rmin_new.val  = b_q.value;
    end else if (b_q.value == rmin_q.val) begin
      rmin_new      = rmin_q;
      rmin_new.uniq = 1'b0;
    end else begin
      rmin_new = rmin_q;
    end
  end

  assign hit       = row_rd_q.uniq && col_rd_q.uniq && (col_rd_q.max == row_rd_q.val);
  assign walk_done = hit || (walk_q == last_row_q);
  assign load      = (state_q == S_WALK_CHK) && walk_done && (!out_valid_q || pop);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_STREAM: begin
        if (take && in_item.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:    state_d = S_WALK_ROW;
      S_WALK_ROW: state_d = S_WALK_COL;
      S_WALK_COL: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (load) begin
          state_d = S_STREAM;
        end else if (!walk_done) begin
          state_d = S_WALK_ROW;
        end
      end
      default:    state_d = S_STREAM;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (col_re) begin
      col_rd_q <= col_mem[col_raddr];
    end
    if (state_q == S_WALK_ROW) begin
      row_rd_q <= row_mem[walk_q];
    end
    if (b_valid_q) begin
      col_mem[b_q.col] <= col_new;
      if (b_q.row_end) begin
        row_mem[b_q.row] <= rmin_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b_q <= in_item;
    end
    if (take && in_item.last) begin
      last_row_q <= in_item.row;
    end
    if (b_valid_q) begin
      rmin_q     <= rmin_new;
      wr_col_q   <= b_q.col;
      wr_entry_q <= col_new;
    end
    if (load) begin
      found_q   <= hit;
      value_q   <= hit ? row_rd_q.val : '0;
      res_row_q <= hit ? walk_q : '0;
      res_col_q <= hit ? row_rd_q.col : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_STREAM;
      b_valid_q   <= 1'b0;
      wr_valid_q  <= 1'b0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      b_valid_q  <= take;
      wr_valid_q <= b_valid_q;
      if (state_q == S_DRAIN) begin
        walk_q <= '0;
      end else if (state_q == S_WALK_CHK && !walk_done) begin
        walk_q <= walk_q + RowW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty          = !out_valid_q;
  assign found_o        = found_q;
  assign point_value_o  = value_q;
  assign point_row_o    = PointIdxW'(res_row_q);
  assign point_column_o = PointIdxW'(res_col_q);

endmodule

// ----- rtl/core/matrix_saddle_point_finder.sv -----
// Matrix saddle point finder. Elements enter one per cycle, while full is low, in row-major
// order through a push/full port; each is tagged with its row and column in the front end and
// queued. The back end reads the stored column maximum, then updates it and the running row
// minimum, taking the next element before the previous update is written. The last element of
// the matrix starts a walk over the rows, each a row store read, a column store read and a
// compare. One result per matrix appears on the empty/pop port; elements of the next matrix
// are queued while the walk runs. Writing either count register restarts the matrix at row
// zero, column zero; write only while idle.
module matrix_saddle_point_finder import msp_pkg::*; #(
  parameter int MAX_ROWS    = DefMaxRows,
  parameter int MAX_COLUMNS = DefMaxColumns
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [ValueW-1:0]  element_value_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      found_o,
  output logic signed [ValueW-1:0]  point_value_o,
  output logic [PointIdxW-1:0]      point_row_o,
  output logic [PointIdxW-1:0]      point_column_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ItemW = ValueW + RowW + ColW + 2;

  logic             fe_valid, fe_ready, be_valid, be_ready;
  logic [ItemW-1:0] fe_item, be_item;

  msp_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .element_value_i (element_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .item_valid_o    (fe_valid),
    .item_o          (fe_item),
    .item_ready_i    (fe_ready)
  );

  msp_fifo #(
    .WIDTH (ItemW),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_item),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready),
    .rd_data_o  (be_item)
  );

  msp_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (be_valid),
    .item_ready_o   (be_ready),
    .item_i         (be_item),
    .empty          (empty),
    .pop            (pop),
    .found_o        (found_o),
    .point_value_o  (point_value_o),
    .point_row_o    (point_row_o),
    .point_column_o (point_column_o)
  );

endmodule

// ----- rtl/core/msp_checker.sv -----
// Port-level checks for the matrix saddle point finder, bound to the top level.
// Depends on msp_pkg.
module msp_checker import msp_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic                     found_o,
  input logic signed [ValueW-1:0] point_value_o,
  input logic [PointIdxW-1:0]     point_row_o,
  input logic [PointIdxW-1:0]     point_column_o
);

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result shown right after reset");

  a_zero_when_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |->
      (point_value_o == '0 && point_row_o == '0 && point_column_o == '0))
    else $error("no saddle point but nonzero payload");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(found_o) && $stable(point_value_o)
       && $stable(point_row_o) && $stable(point_column_o)))
    else $error("waiting result changed or dropped");

endmodule

bind matrix_saddle_point_finder msp_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .found_o        (found_o),
  .point_value_o  (point_value_o),
  .point_row_o    (point_row_o),
  .point_column_o (point_column_o)
);

// ----- tb/matrix_saddle_point_finder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for matrix_saddle_point_finder: streams matrices through the push/full
// port and checks each saddle point result against a predictor of its own or a directed expected value.
// Depends on msp_pkg and the RTL of the block only.
module matrix_saddle_point_finder_tb;
  import msp_pkg::*;

  localparam int ItemTarget  = 700;
  localparam int DrainCycles = 3 * DefMaxRows + 2 * FifoDepth + 20;
  localparam int HoldAfter   = 16;
  localparam int HoldCycles  = 400;
  localparam int QuietLimit  = 2000;

  localparam logic [CfgIdxW-1:0] RegUnusedLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegUnusedHi = CfgIdxW'(3);

  typedef struct packed {
    logic                 found;
    logic [ValueW-1:0]    value;
    logic [PointIdxW-1:0] row;
    logic [PointIdxW-1:0] column;
  } saddle_t;

  typedef enum logic {ROW_ELEMENT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] index;
    logic [ValueW-1:0]  data;
    logic               typed;
    saddle_t            want;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [ValueW-1:0]   element_value_i = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic                       found_o;
  logic signed [ValueW-1:0]   point_value_o;
  logic [PointIdxW-1:0]       point_row_o;
  logic [PointIdxW-1:0]       point_column_o;
  logic                       cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i = '0;

  matrix_saddle_point_finder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .element_value_i(element_value_i),
    .empty          (empty),
    .pop            (pop),
    .found_o        (found_o),
    .point_value_o  (point_value_o),
    .point_row_o    (point_row_o),
    .point_column_o (point_column_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor state
  logic signed [ValueW-1:0] col_peak       [DefMaxColumns];
  bit                       col_peak_single[DefMaxColumns];
  logic signed [ValueW-1:0] row_low        [DefMaxRows];
  int unsigned              row_low_col    [DefMaxRows];
  bit                       row_low_single [DefMaxRows];
  int unsigned              at_row = 0;
  int unsigned              at_col = 0;
  logic [CfgDataW-1:0]      rows_reg = CfgDataW'(1);
  logic [CfgDataW-1:0]      cols_reg = CfgDataW'(1);

  saddle_t           pending_saddles[$];
  logic [ValueW-1:0] grid[DefMaxRows][DefMaxColumns];
  int                mismatches = 0;
  int                elements_sent = 0;
  int                send_burst = 0;
  int                take_burst = 0;
  int                quiet_cycles = 0;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned effective_count(logic [CfgDataW-1:0] raw, int unsigned bound);
    if (raw == 0) return 1;
    if (raw > bound) return bound;
    return raw;
  endfunction

  function automatic void track_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == RegRowCount) begin
      rows_reg = data;
    end else if (idx == RegColumnCount) begin
      cols_reg = data;
    end else begin
      return;
    end
    at_row = 0;
    at_col = 0;
  endfunction

  function automatic bit track_element(logic signed [ValueW-1:0] v, output saddle_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    rows = effective_count(rows_reg, DefMaxRows);
    cols = effective_count(cols_reg, DefMaxColumns);
    r = at_row;
    c = at_col;
    res = '0;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    if (c == 0 || v < row_low[r]) begin
      row_low[r] = v;
      row_low_col[r] = c;
      row_low_single[r] = 1'b1;
    end else if (v == row_low[r]) begin
      row_low_single[r] = 1'b0;
    end
    if (r == 0 || v > col_peak[c]) begin
      col_peak[c] = v;
      col_peak_single[c] = 1'b1;
    end else if (v == col_peak[c]) begin
      col_peak_single[c] = 1'b0;
    end
    c++;
    if (c < cols) begin
      at_row = r;
      at_col = c;
      return 1'b0;
    end
    r++;
    at_col = 0;
    if (r < rows) begin
      at_row = r;
      return 1'b0;
    end
    at_row = 0;
    for (int i = 0; i < rows; i++) begin
      if (row_low_single[i] && col_peak_single[row_low_col[i]]
          && col_peak[row_low_col[i]] == row_low[i]) begin
        res.found  = 1'b1;
        res.value  = row_low[i];
        res.row    = PointIdxW'(i);
        res.column = PointIdxW'(row_low_col[i]);
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic stim_row_t element_row(logic [ValueW-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ELEMENT;
    r.data = v;
    return r;
  endfunction

  // last element of a matrix whose result is plain: either that element at row 0,
  // column 0, or nothing found
  function automatic stim_row_t closing_element(logic [ValueW-1:0] v, logic hit);
    stim_row_t r;
    r = element_row(v);
    r.typed = 1'b1;
    r.want.found = hit;
    r.want.value = hit ? v : '0;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.data = ValueW'(data);
    return r;
  endfunction

  function automatic void fill_grid(int rows, int cols);
    int mode;
    int base;
    int pr;
    int pc;
    mode = $urandom_range(0, 19);
    base = int'($urandom_range(0, 2000000)) - 1000000;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (mode < 4 || mode >= 9) begin
          grid[r][c] = $urandom;
        end else if (mode < 7) begin
          grid[r][c] = ValueW'(int'($urandom_range(0, 4)) - 2);
        end else begin
          case ($urandom_range(0, 3))
            0: grid[r][c] = 32'h8000_0000;
            1: grid[r][c] = 32'h7fff_ffff;
            2: grid[r][c] = '0;
            default: grid[r][c] = '1;
          endcase
        end
      end
    end
    if (mode >= 9) begin
      // plant a strict saddle point, then maybe spoil it with a tie
      pr = $urandom_range(0, rows - 1);
      pc = $urandom_range(0, cols - 1);
      for (int c = 0; c < cols; c++) grid[pr][c] = base + 1 + int'($urandom_range(0, 999));
      for (int r = 0; r < rows; r++) grid[r][pc] = base - 1 - int'($urandom_range(0, 999));
      grid[pr][pc] = base;
      if (mode >= 17) begin
        if (cols > 1 && (rows == 1 || $urandom_range(0, 1) == 1)) begin
          grid[pr][(pc + int'($urandom_range(1, cols - 1))) % cols] = base;
        end else if (rows > 1) begin
          grid[(pr + int'($urandom_range(1, rows - 1))) % rows][pc] = base;
        end
      end
    end
  endfunction

  task automatic send_element(input logic [ValueW-1:0] v, input logic typed, input saddle_t want);
    int gap;
    saddle_t res;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (full);
    elements_sent++;
    if (track_element(v, res)) pending_saddles.push_back(typed ? want : res);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    push <= 1'b0;
    while (pending_saddles.size() != 0) @(posedge clk_i);
    // let queued elements of an unfinished matrix settle
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    track_register(idx, data);
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] rows_raw,
                           input logic [CfgDataW-1:0] cols_raw, input int budget);
    int rows;
    int cols;
    int sent;
    int cut;
    int spare_at;
    write_register(RegRowCount, rows_raw);
    write_register(RegColumnCount, cols_raw);
    rows = effective_count(rows_raw, DefMaxRows);
    cols = effective_count(cols_raw, DefMaxColumns);
    sent = 0;
    while (sent < budget) begin
      fill_grid(rows, cols);
      cut = rows * cols;
      spare_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, rows * cols - 1)) : -1;
      // drop the tail of the last matrix now and then; the next write restarts it
      if (sent > 0 && sent + cut >= budget && $urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, rows * cols);
      end
      for (int k = 0; k < cut; k++) begin
        if (k == spare_at) begin
          write_register($urandom_range(0, 1) ? RegUnusedLo : RegUnusedHi, $urandom);
        end
        send_element(grid[k / cols][k % cols], 1'b0, '0);
      end
      sent += cut;
    end
  endtask

  initial begin : stimulus
    stim_row_t directed[$];
    wait (rst_ni);
    @(posedge clk_i);

    directed.push_back(closing_element(32'd5, 1'b1));
    directed.push_back(closing_element(32'h8000_0000, 1'b1));
    directed.push_back(closing_element(32'h7fff_ffff, 1'b1));
    directed.push_back(write_row(RegRowCount, CfgDataW'(2)));
    directed.push_back(write_row(RegColumnCount, CfgDataW'(2)));
    directed.push_back(element_row(32'd1));
    directed.push_back(element_row(32'd2));
    directed.push_back(element_row(32'd0));
    directed.push_back(element_row(32'd3));
    directed.push_back(element_row(32'd5));
    directed.push_back(element_row(32'd5));
    directed.push_back(element_row(32'd1));
    directed.push_back(closing_element(32'd2, 1'b0));
    directed.push_back(element_row(32'd7));
    directed.push_back(write_row(RegColumnCount, CfgDataW'(2)));
    directed.push_back(element_row(32'd4));
    directed.push_back(element_row(32'd9));
    directed.push_back(element_row(32'd3));
    directed.push_back(element_row(32'd8));
    directed.push_back(element_row(32'd6));
    directed.push_back(write_row(RegUnusedLo, CfgDataW'(7'h7f)));
    directed.push_back(element_row(32'd8));
    directed.push_back(element_row(32'd1));
    directed.push_back(element_row(32'd9));
    directed.push_back(write_row(RegUnusedHi, CfgDataW'(0)));
    directed.push_back(write_row(RegRowCount, CfgDataW'(0)));
    directed.push_back(write_row(RegColumnCount, CfgDataW'(3)));
    directed.push_back(element_row(-32'sd3));
    directed.push_back(element_row(32'd4));
    directed.push_back(closing_element(-32'sd3, 1'b0));
    directed.push_back(write_row(RegColumnCount, CfgDataW'(1)));
    directed.push_back(write_row(RegRowCount, CfgDataW'(3)));
    directed.push_back(element_row(32'd2));
    directed.push_back(element_row(32'd9));
    directed.push_back(element_row(-32'sd4));

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_WRITE) begin
        write_register(directed[k].index, directed[k].data[CfgDataW-1:0]);
      end else begin
        send_element(directed[k].data, directed[k].typed, directed[k].want);
      end
    end

    run_phase($urandom_range(1, 3), $urandom_range(1, 3), 160);
    run_phase(CfgDataW'(0), CfgDataW'(127), 64);
    run_phase(CfgDataW'(127), CfgDataW'(1), 64);
    run_phase(CfgDataW'(2), CfgDataW'(DefMaxColumns), 128);
    run_phase(CfgDataW'(DefMaxRows), CfgDataW'(2), 128);
    while (elements_sent < ItemTarget) begin
      run_phase($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(30, 60));
    end

    push <= 1'b0;
    while (pending_saddles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_check
    saddle_t want;
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      // hold off once for a long stretch so the block backs up into its input
      gap = (taken == HoldAfter) ? HoldCycles : draw_gap(take_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      taken++;
      if (pending_saddles.size() == 0) begin
        $error("result with nothing pending: found=%0d value=%0d row=%0d column=%0d",
               found_o, point_value_o, point_row_o, point_column_o);
        mismatches++;
      end else begin
        want = pending_saddles.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatches++;
        end
        if (point_value_o !== want.value) begin
          $error("point_value: expected %0d, got %0d", $signed(want.value), point_value_o);
          mismatches++;
        end
        if (point_row_o !== want.row) begin
          $error("point_row: expected %0d, got %0d", want.row, point_row_o);
          mismatches++;
        end
        if (point_column_o !== want.column) begin
          $error("point_column: expected %0d, got %0d", want.column, point_column_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/core/msp_pkg.sv
rtl/core/msp_front.sv
rtl/core/msp_fifo.sv
rtl/core/msp_back.sv
rtl/core/matrix_saddle_point_finder.sv
rtl/core/msp_checker.sv
tb/matrix_saddle_point_finder_tb.sv
